### rtl/dts_pkg.sv
// Shared types, codes and constants of the deadline task scheduler.
`default_nettype none
package dts_pkg;

  // Default table depth and fixed field widths
  localparam int DTS_NUM_TASKS = 8;
  localparam int OPCODE_W      = 3;
  localparam int TASK_W        = 3;
  localparam int VALUE_W       = 16;
  localparam int CPT_W         = 11;
  localparam int HORIZON_W     = 16;
  localparam int TTE_W         = 32;
  localparam int BYTE_W        = 8;
  localparam int PROD_W        = VALUE_W + CPT_W;
  localparam int CFG_IDX_W     = 4;

  // Register reset values
  localparam logic [CPT_W-1:0]     CPT_RESET     = 11'd1;
  localparam logic [HORIZON_W-1:0] HORIZON_RESET = 16'd60000;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADVANCE   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_EVENT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_LAT   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SET_RSV   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_NEXT_CLK  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_NEXT_TICK = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SCHEDULE  = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 4'd1;

  // Task table field codes
  localparam logic [1:0] FLD_EVENT = 2'd0;
  localparam logic [1:0] FLD_LAT   = 2'd1;
  localparam logic [1:0] FLD_RSV   = 2'd2;
  localparam logic [1:0] FLD_TTE   = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [TASK_W-1:0]   task_id;
    logic [VALUE_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic [TASK_W-1:0]  selected_task;
    logic [VALUE_W-1:0] interval;
  } out_beat_t;

  // Write request into the task table
  typedef struct packed {
    logic             en;
    logic [1:0]       field;
    logic [TTE_W-1:0] data;
  } tbl_wr_t;

  // One task entry as read from the table
  typedef struct packed {
    logic [BYTE_W-1:0] event_code;
    logic [BYTE_W-1:0] latency;
    logic [BYTE_W-1:0] reserve;
    logic [TTE_W-1:0]  tte;
  } tbl_entry_t;

endpackage
`default_nettype wire

### rtl/dts_mult.sv
// Shared registered multiplier for tick scaling and reserve scaling.
`default_nettype none
module dts_mult
  import dts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [VALUE_W-1:0] mul_a,
  input  wire logic [CPT_W-1:0]   mul_b,
  output logic      [PROD_W-1:0]  prod_r
);

  // Register the product, ready in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule
`default_nettype wire

### rtl/dts_table.sv
// Task table: per-task event code, latency, reserve and time-to-event.
`default_nettype none
module dts_table
  import dts_pkg::*;
#(
  parameter  int NUM_TASKS = DTS_NUM_TASKS,
  localparam int IDX_W     = $clog2(NUM_TASKS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tbl_wr_t          wr,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [IDX_W-1:0] rd_idx,
  output tbl_entry_t            rd
);

  logic [BYTE_W-1:0] event_code_r [NUM_TASKS];
  logic [BYTE_W-1:0] latency_r    [NUM_TASKS];
  logic [BYTE_W-1:0] reserve_r    [NUM_TASKS];
  logic [TTE_W-1:0]  tte_r        [NUM_TASKS];

  // Clear on reset, write one field of one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        event_code_r[i] <= '0;
        latency_r[i]    <= '0;
        reserve_r[i]    <= '0;
        tte_r[i]        <= '0;
      end
    end else if (wr.en) begin
      case (wr.field)
        FLD_EVENT: event_code_r[wr_idx] <= wr.data[BYTE_W-1:0];
        FLD_LAT:   latency_r[wr_idx]    <= wr.data[BYTE_W-1:0];
        FLD_RSV:   reserve_r[wr_idx]    <= wr.data[BYTE_W-1:0];
        FLD_TTE:   tte_r[wr_idx]        <= wr.data;
        default: ;
      endcase
    end
  end

  // Select the addressed entry
  always_comb begin
    rd.event_code = event_code_r[rd_idx];
    rd.latency    = latency_r[rd_idx];
    rd.reserve    = reserve_r[rd_idx];
    rd.tte        = tte_r[rd_idx];
  end

endmodule
`default_nettype wire

### rtl/deadline_task_scheduler.sv
// Deadline task scheduler top level: opcode sequencer around the task table.
// Set, advance and next-in-clocks beats are handled on accept; next-in-ticks adds a multiply and a write step.
// Schedule: a first pass over all entries, one reserve multiply, a second pass up to the pick,
// then one load of the result into the output register.
// The input is stalled while a beat is in progress, and longer while a result is held.
// Synchronous reset clears table and elapsed count, clocks_per_tick 1, horizon 60000.
`default_nettype none
module deadline_task_scheduler
  import dts_pkg::*;
#(
  parameter  int NUM_TASKS = DTS_NUM_TASKS,
  localparam int IDX_W     = $clog2(NUM_TASKS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VALUE_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_TICK_MUL = 3'd1;
  localparam logic [2:0] ST_TICK_WR  = 3'd2;
  localparam logic [2:0] ST_P1       = 3'd3;
  localparam logic [2:0] ST_RMUL     = 3'd4;
  localparam logic [2:0] ST_P2       = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     sel_r, sel_nxt;
  logic signed [31:0]   bound_r, bound_nxt;
  logic [VALUE_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CPT_W-1:0]     cpt_r;
  logic [HORIZON_W-1:0] horizon_r;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0]     tidx_r, tidx_nxt;
  logic [BYTE_W-1:0]    rsv_r, rsv_nxt;
  logic                 out_valid_r;
  out_beat_t            out_data_r, out_data_nxt;

  tbl_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  tbl_entry_t       rd;
  logic [VALUE_W-1:0] mul_a;
  logic [PROD_W-1:0]  prod_r;

  logic               in_fire;
  logic               ti_ok;
  logic [IDX_W-1:0]   ti_idx;
  logic [VALUE_W:0]   adv_sum;
  logic [TTE_W-1:0]   t_sub;
  logic               pending;
  logic               hit;
  logic               out_load;
  logic [VALUE_W-1:0] iv;

  dts_table #(.NUM_TASKS(NUM_TASKS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .wr_idx (wr_idx),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  dts_mult u_mult (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (cpt_r),
    .prod_r (prod_r)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode helpers
  assign ti_ok   = (32'(in_data.task_id) < NUM_TASKS);
  assign ti_idx  = IDX_W'(in_data.task_id);
  assign adv_sum = {1'b0, elapsed_r} + {1'b0, in_data.value};
  assign t_sub   = rd.tte - TTE_W'(elapsed_r);
  assign pending = (rd.event_code != '0);
  assign hit     = pending && ((rd.latency < rsv_r) ||
                   ($signed(rd.tte) < $signed(TTE_W'(prod_r))));
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  // Hold the reserve on the multiplier through the second pass
  assign mul_a   = (state_r == ST_RMUL) ? VALUE_W'(rd.reserve) :
                   (state_r == ST_P2)   ? VALUE_W'(rsv_r)      : val_r;

  // Saturate the final bound into the interval
  always_comb begin
    if (bound_r > 32'sd0) begin
      iv = (bound_r > 32'sd65535) ? '1 : bound_r[VALUE_W-1:0];
    end else begin
      iv = '0;
    end
  end

  // Sequencer: decode beats, run both scheduling passes
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    sel_nxt      = sel_r;
    bound_nxt    = bound_r;
    elapsed_nxt  = elapsed_r;
    val_nxt      = val_r;
    tidx_nxt     = tidx_r;
    rsv_nxt      = rsv_r;
    out_data_nxt = out_data_r;
    wr.en        = 1'b0;
    wr.field     = FLD_TTE;
    wr.data      = '0;
    wr_idx       = ti_idx;
    rd_idx       = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_ADVANCE: begin
              elapsed_nxt = adv_sum[VALUE_W] ? '1 : adv_sum[VALUE_W-1:0];
            end
            OP_SET_EVENT: begin
              wr.en    = ti_ok;
              wr.field = FLD_EVENT;
              wr.data  = TTE_W'(in_data.value[BYTE_W-1:0]);
            end
            OP_SET_LAT: begin
              wr.en    = ti_ok;
              wr.field = FLD_LAT;
              wr.data  = TTE_W'(in_data.value[BYTE_W-1:0]);
            end
            OP_SET_RSV: begin
              wr.en    = ti_ok;
              wr.field = FLD_RSV;
              wr.data  = TTE_W'(in_data.value[BYTE_W-1:0]);
            end
            OP_NEXT_CLK: begin
              wr.en    = ti_ok;
              wr.field = FLD_TTE;
              wr.data  = TTE_W'(elapsed_r) + TTE_W'(in_data.value);
            end
            OP_NEXT_TICK: begin
              val_nxt  = in_data.value;
              tidx_nxt = ti_idx;
              if (ti_ok) begin
                state_nxt = ST_TICK_MUL;
              end
            end
            OP_SCHEDULE: begin
              cnt_nxt   = IDX_W'(NUM_TASKS - 1);
              sel_nxt   = '0;
              bound_nxt = $signed(TTE_W'(horizon_r));
              state_nxt = ST_P1;
            end
            default: ;
          endcase
        end
      end
      ST_TICK_MUL: begin
        state_nxt = ST_TICK_WR;
      end
      ST_TICK_WR: begin
        wr.en     = 1'b1;
        wr.field  = FLD_TTE;
        wr.data   = TTE_W'(elapsed_r) + TTE_W'(prod_r);
        wr_idx    = tidx_r;
        state_nxt = ST_IDLE;
      end
      ST_P1: begin
        // Age the entry, then take it as the earliest or an overdue pick
        wr.en    = 1'b1;
        wr.field = FLD_TTE;
        wr.data  = t_sub;
        wr_idx   = cnt_r;
        if (pending) begin
          if ($signed(t_sub) <= bound_r) begin
            bound_nxt = $signed(t_sub);
            sel_nxt   = cnt_r;
          end else if ($signed(t_sub) <= 32'sd0) begin
            sel_nxt = cnt_r;
          end
        end
        if (cnt_r == '0) begin
          elapsed_nxt = '0;
          state_nxt   = ST_RMUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_RMUL: begin
        // Scale the pick's reserve into clocks
        rd_idx    = sel_r;
        rsv_nxt   = rd.reserve;
        cnt_nxt   = '0;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        // Let the first blocking higher-priority task take over
        if (cnt_r == sel_r) begin
          state_nxt = ST_FIN;
        end else if (hit) begin
          bound_nxt = $signed(rd.tte);
          sel_nxt   = cnt_r;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_data_nxt.selected_task = TASK_W'(sel_r);
          out_data_nxt.interval      = iv;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= '0;
      bound_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      sel_r     <= sel_nxt;
      bound_r   <= bound_nxt;
      elapsed_r <= elapsed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    tidx_r     <= tidx_nxt;
    rsv_r      <= rsv_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpt_r     <= CPT_RESET;
      horizon_r <= HORIZON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CPT) begin
        cpt_r <= cfg_data[CPT_W-1:0];
      end else if (cfg_index == CFG_HORIZON) begin
        horizon_r <= cfg_data[HORIZON_W-1:0];
      end
    end
  end

  // A result beat appears only after the finishing step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result beat raised outside the finishing step");

  // The first pass runs on until the reserve multiply
  a_p1_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P1) |=> (state_r == ST_P1 || state_r == ST_RMUL))
    else $error("first pass left early");

  // Elapsed time is cleared once the first pass is done
  a_elapsed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMUL) |-> (elapsed_r == '0))
    else $error("elapsed counter not cleared after first pass");

  // The pick always names a real table entry
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sel_r) < NUM_TASKS)
    else $error("selected index beyond task table");

  // The second pass never scans past the pick
  a_p2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P2) |-> (cnt_r <= sel_r))
    else $error("second pass scanned past the pick");

endmodule
`default_nettype wire
